// ===== hdl/lpfk_pkg.sv =====
// Shared constants for the layout pair force kernel.
`timescale 1ns / 1ps
package lpfk_pkg;
	localparam int COORD_W    = 24;
	localparam int MAG_W      = COORD_W + 1;
	localparam int FRAC_W     = 8;
	localparam int LEN_W      = 24;
	localparam int SIZE_W     = 16;
	localparam int WEIGHT_W   = 16;
	localparam int CAP_W      = 32;
	localparam int FORCE_W    = 32;
	localparam int REG_IDX_W  = 3;
	localparam int CFG_DATA_W = 32;

	// factor format: unsigned, FACT_FRAC fraction bits, saturates at FACT_MAX
	localparam int FACT_FRAC = 24;
	localparam int FACT_W    = 56;
	localparam int HALF_W    = FACT_W / 2;
	localparam logic [FACT_W-1:0] FACT_MAX = {1'b1, {(FACT_W-1){1'b0}}};

	localparam int SQ_IN_W  = 2 * MAG_W;
	localparam int SQ_OUT_W = MAG_W;
	localparam int SQ_REM_W = SQ_OUT_W + 1;
	localparam int SQ_LAT   = SQ_OUT_W + 1;

	localparam int RADSUM_W   = 32;
	localparam int K_W        = RADSUM_W + 1;
	localparam int SROOT_W    = SIZE_W;
	localparam int SSUM_W     = SROOT_W + 1;
	localparam logic [SROOT_W-1:0] ROOT_ZERO = SROOT_W'((2 << FRAC_W) / 3);

	localparam int DIV_N_W   = CAP_W + WEIGHT_W;
	localparam int DIV_D_W   = RADSUM_W + FRAC_W;
	localparam int DIV_TOP_W = FACT_W - FACT_FRAC;
	localparam int DIV_LAT   = FACT_W + 1;
	localparam int MUL_LAT   = 3;

	localparam logic [REG_IDX_W-1:0] REG_EDGE_LENGTH  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_RADIUS_UNIT  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_SPRING_WGT   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_FORCE_CAP    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_LAYOUT_3D    = 3'd4;
endpackage

// ===== hdl/lpfk_isqrt.sv =====
// Pipelined integer square root, one root bit per stage.
`timescale 1ns / 1ps
module lpfk_isqrt (
	input  logic clk,
	input  logic arst_n,
	input  logic in_v,
	input  logic [lpfk_pkg::SQ_IN_W-1:0] x,
	output logic out_v,
	output logic [lpfk_pkg::SQ_OUT_W-1:0] root
);
	import lpfk_pkg::*;

	logic [SQ_OUT_W:0] v_s;
	logic [SQ_IN_W-1:0] x_s [SQ_OUT_W];
	logic [SQ_REM_W-1:0] rem_s [SQ_OUT_W];
	logic [SQ_OUT_W-1:0] root_s [SQ_OUT_W+1];
	logic [SQ_REM_W+1:0] t [1:SQ_OUT_W];
	logic [SQ_REM_W+1:0] trial [1:SQ_OUT_W];
	logic [SQ_OUT_W:1] take;

	always_comb begin
		for (int j = 1; j <= SQ_OUT_W; j++) begin
			t[j] = {rem_s[j-1], x_s[j-1][2*(SQ_OUT_W-j)+1 -: 2]};
			trial[j] = {1'b0, root_s[j-1], 2'b01};
			take[j] = t[j] >= trial[j];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[SQ_OUT_W-1:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		x_s[0] <= x;
		rem_s[0] <= '0;
		root_s[0] <= '0;
		for (int j = 1; j <= SQ_OUT_W; j++) begin
			root_s[j] <= {root_s[j-1][SQ_OUT_W-2:0], take[j]};
			if (j < SQ_OUT_W) begin
				x_s[j] <= x_s[j-1];
				rem_s[j] <= take[j] ? SQ_REM_W'(t[j] - trial[j]) : t[j][SQ_REM_W-1:0];
			end
		end
	end

	assign out_v = v_s[SQ_OUT_W];
	assign root = root_s[SQ_OUT_W];
endmodule

// ===== hdl/lpfk_div.sv =====
// Pipelined restoring divider: saturated factor num * 2^FACT_FRAC / den.
`timescale 1ns / 1ps
module lpfk_div (
	input  logic clk,
	input  logic arst_n,
	input  logic in_v,
	input  logic [lpfk_pkg::DIV_N_W-1:0] num,
	input  logic [lpfk_pkg::DIV_D_W-1:0] den,
	output logic out_v,
	output logic [lpfk_pkg::FACT_W-1:0] quo
);
	import lpfk_pkg::*;

	localparam int OVF_SH = FACT_W - 1 - FACT_FRAC;

	logic [FACT_W:0] v_s;
	logic ovf_s [FACT_W+1];
	logic zr_s [FACT_W+1];
	logic [FACT_W-1:0] q_s [FACT_W+1];
	logic [DIV_D_W-1:0] d_s [FACT_W];
	logic [DIV_D_W-1:0] rem_s [FACT_W];
	logic [DIV_TOP_W-1:0] bits_s [FACT_W];
	logic [DIV_D_W:0] t [1:FACT_W];
	logic [DIV_D_W-1:0] rem_nx [1:FACT_W];
	logic [FACT_W:1] take;

	always_comb begin
		for (int j = 1; j <= FACT_W; j++) begin
			t[j] = {rem_s[j-1], bits_s[j-1][DIV_TOP_W-1]};
			take[j] = t[j] >= {1'b0, d_s[j-1]};
			rem_nx[j] = take[j] ? DIV_D_W'(t[j] - {1'b0, d_s[j-1]}) : t[j][DIV_D_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= '0;
		end else begin
			v_s <= {v_s[FACT_W-1:0], in_v};
		end
	end

	always_ff @(posedge clk) begin
		// quotient of 2^31 or more, or any nonzero over zero, saturates
		ovf_s[0] <= (num != '0) && (DIV_D_W'(num[DIV_N_W-1:OVF_SH]) >= den);
		zr_s[0] <= num == '0;
		q_s[0] <= '0;
		d_s[0] <= den;
		rem_s[0] <= DIV_D_W'(num[DIV_N_W-1:DIV_TOP_W]);
		bits_s[0] <= num[DIV_TOP_W-1:0];
		for (int j = 1; j <= FACT_W; j++) begin
			ovf_s[j] <= ovf_s[j-1];
			zr_s[j] <= zr_s[j-1];
			q_s[j] <= {q_s[j-1][FACT_W-2:0], take[j]};
			if (j < FACT_W) begin
				d_s[j] <= d_s[j-1];
				rem_s[j] <= rem_nx[j];
				bits_s[j] <= {bits_s[j-1][DIV_TOP_W-2:0], 1'b0};
			end
		end
	end

	assign out_v = v_s[FACT_W];
	assign quo = ovf_s[FACT_W] ? FACT_MAX : (zr_s[FACT_W] ? '0 : q_s[FACT_W]);
endmodule

// ===== hdl/lpfk_mul.sv =====
// Three-stage factor multiply: (a * b) >> FACT_FRAC, saturated at FACT_MAX.
`timescale 1ns / 1ps
module lpfk_mul (
	input  logic clk,
	input  logic arst_n,
	input  logic in_v,
	input  logic [lpfk_pkg::FACT_W-1:0] a,
	input  logic [lpfk_pkg::FACT_W-1:0] b,
	output logic out_v,
	output logic [lpfk_pkg::FACT_W-1:0] p
);
	import lpfk_pkg::*;

	localparam int PROD_W = 2 * FACT_W;
	localparam int SH_W = PROD_W - FACT_FRAC;

	logic v_s1, v_s2, v_s3;
	logic [2*HALF_W-1:0] hh_s1, hl_s1, lh_s1, ll_s1;
	logic [2*HALF_W-1:0] hh_s2, ll_s2;
	logic [2*HALF_W:0] mid_s2;
	logic [FACT_W-1:0] p_s3;
	logic [PROD_W-1:0] full;
	logic [SH_W-1:0] sh;

	always_comb begin
		full = {hh_s2, {(2*HALF_W){1'b0}}} + PROD_W'({mid_s2, {HALF_W{1'b0}}})
			+ PROD_W'(ll_s2);
		sh = full[PROD_W-1:FACT_FRAC];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else begin
			v_s1 <= in_v;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		hh_s1 <= a[FACT_W-1:HALF_W] * b[FACT_W-1:HALF_W];
		hl_s1 <= a[FACT_W-1:HALF_W] * b[HALF_W-1:0];
		lh_s1 <= a[HALF_W-1:0] * b[FACT_W-1:HALF_W];
		ll_s1 <= a[HALF_W-1:0] * b[HALF_W-1:0];
		hh_s2 <= hh_s1;
		ll_s2 <= ll_s1;
		mid_s2 <= {1'b0, hl_s1} + {1'b0, lh_s1};
		p_s3 <= (sh > SH_W'(FACT_MAX)) ? FACT_MAX : sh[FACT_W-1:0];
	end

	assign out_v = v_s3;
	assign p = p_s3;
endmodule

// ===== hdl/layout_pair_force_kernel_top.sv =====
// Pair force kernel: pipelined spring / repulsion force between two vertices.
`timescale 1ns / 1ps
// Usage:
//   Input: drive mode, positions, sizes and pref_length with start high; the word
//   is taken at a rising edge where start is high and busy is low. busy stays low,
//   so a new word can be taken in every cycle.
//   Output: done is high for one cycle with force_x/y/z, saturated and coincident;
//   the receiver cannot stall, so nothing ever backs up.
//   Throughput: one word per cycle. The pipeline depth is set by the 26-stage
//   square root of the distance and the 57-stage factor dividers, plus two
//   3-stage factor multipliers for the repulsion power law.
//   Config: cfg_we writes cfg_wdata into register cfg_idx (0 edge length,
//   1 vertex radius unit, 2 spring weight, 3 force cap, 4 3D enable). Write only
//   while no word is in flight.
//   Reset: arst_n clears every valid bit and loads the register defaults; the
//   block is ready in the first cycle after reset is released.
module layout_pair_force_kernel_top (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  logic cfg_we,
	input  logic [lpfk_pkg::REG_IDX_W-1:0] cfg_idx,
	input  logic [lpfk_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic mode,
	input  logic signed [lpfk_pkg::COORD_W-1:0] ax,
	input  logic signed [lpfk_pkg::COORD_W-1:0] ay,
	input  logic signed [lpfk_pkg::COORD_W-1:0] az,
	input  logic signed [lpfk_pkg::COORD_W-1:0] bx,
	input  logic signed [lpfk_pkg::COORD_W-1:0] by,
	input  logic signed [lpfk_pkg::COORD_W-1:0] bz,
	input  logic [lpfk_pkg::SIZE_W-1:0] size_a,
	input  logic [lpfk_pkg::SIZE_W-1:0] size_b,
	input  logic [lpfk_pkg::LEN_W-1:0] pref_length,
	output logic done,
	output logic signed [lpfk_pkg::FORCE_W-1:0] force_x,
	output logic signed [lpfk_pkg::FORCE_W-1:0] force_y,
	output logic signed [lpfk_pkg::FORCE_W-1:0] force_z,
	output logic saturated,
	output logic coincident
);
	import lpfk_pkg::*;

	localparam int SQ_W = 2 * MAG_W;
	localparam int RAD_PROD_W = LEN_W + SSUM_W;
	localparam int PART_W = MAG_W + HALF_W;
	localparam int SCALE_W = PART_W + HALF_W;
	localparam int MAGC_W = FORCE_W + 1;
	localparam logic [MAGC_W-1:0] MAGC_BIG = {1'b1, {FORCE_W{1'b0}}};
	localparam logic [MAGC_W-1:0] POS_LIM = {2'b00, {(FORCE_W-1){1'b1}}};
	localparam logic [MAGC_W-1:0] NEG_LIM = {2'b01, {(FORCE_W-1){1'b0}}};

	typedef struct packed {
		logic spring;
		logic coin;
		logic [2:0] sgn;
		logic [2:0][MAG_W-1:0] u;
		logic [LEN_W-1:0] pl;
		logic za;
		logic zb;
	} front_t;

	typedef struct packed {
		logic spring;
		logic neg;
		logic ge;
		logic coin;
		logic [2:0] sgn;
		logic [2:0][MAG_W-1:0] u;
	} back_t;

	typedef struct packed {
		back_t b;
		logic [FACT_W-1:0] fa;
		logic [FACT_W-1:0] fb;
	} mid_t;

	typedef struct packed {
		mid_t m;
		logic [FACT_W-1:0] rr;
	} late_t;

	// configuration
	logic [LEN_W-1:0] edge_length_q, radius_unit_q;
	logic [WEIGHT_W-1:0] spring_weight_q;
	logic [CAP_W-1:0] force_cap_q;
	logic layout_3d_q;

	// front end
	logic signed [COORD_W:0] pa [3];
	logic signed [COORD_W:0] pb [3];
	logic signed [COORD_W:0] dd [3];
	front_t front_in;
	logic v_s1, v_s2, v_s3;
	front_t front_s1, front_s2, front_s3;
	logic [SIZE_W-1:0] sa_s1, sb_s1, sa_s2, sb_s2, sa_s3, sb_s3;
	logic [SQ_W-1:0] sq_s2 [3];
	logic [SQ_W-1:0] sum_s3;

	// square roots
	logic vq;
	logic [SQ_OUT_W-1:0] root_d, root_a, root_b;
	front_t fdl_q [SQ_LAT];

	// radius and divider set-up
	logic v_s4, v_s5, v_s6, v_s7;
	front_t front_s4, front_s5;
	logic [SQ_OUT_W-1:0] dist_s4, dist_s5, dist_s6;
	logic [SSUM_W-1:0] ssum_s4;
	logic [RAD_PROD_W-1:0] rad_prod;
	logic [RADSUM_W-1:0] radsum_s5;
	logic [RADSUM_W-1:0] dist_w, pref_c, num_c;
	logic [K_W-1:0] k_c;
	logic [RADSUM_W-1:0] pref_s6, num_s6;
	logic [K_W-1:0] k_s6;
	back_t back_c, back_s6, back_s7;
	logic [DIV_N_W-1:0] na_s7, nb_s7;
	logic [DIV_D_W-1:0] da_s7, db_s7;

	// dividers and factor multipliers
	logic vd, vm1, vm2;
	logic [FACT_W-1:0] fa, fb, rr, rrr;
	back_t bdl_q [DIV_LAT];
	mid_t m1_q [MUL_LAT];
	late_t m2_q [MUL_LAT];

	// factor select and scaling
	logic [FACT_W-1:0] g_c, f_c;
	logic v_s8, v_s9, v_s10;
	back_t back_s8, back_s9, back_s10;
	logic [FACT_W-1:0] f_s8;
	logic [PART_W-1:0] ph_s9 [3];
	logic [PART_W-1:0] pl_s9 [3];
	logic [SCALE_W-1:0] prod_c [3];
	logic [SCALE_W-FACT_FRAC-1:0] mag_c [3];
	logic [MAGC_W-1:0] magc_s10 [3];

	// output
	logic [FORCE_W-1:0] val_c [3];
	logic sat_c [3];
	logic cneg;
	logic [MAGC_W-1:0] mm;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_length_q <= LEN_W'(2560);
			radius_unit_q <= LEN_W'(2560);
			spring_weight_q <= WEIGHT_W'(256);
			force_cap_q <= '1;
			layout_3d_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx)
				REG_EDGE_LENGTH: edge_length_q <= cfg_wdata[LEN_W-1:0];
				REG_RADIUS_UNIT: radius_unit_q <= cfg_wdata[LEN_W-1:0];
				REG_SPRING_WGT:  spring_weight_q <= cfg_wdata[WEIGHT_W-1:0];
				REG_FORCE_CAP:   force_cap_q <= cfg_wdata[CAP_W-1:0];
				REG_LAYOUT_3D:   layout_3d_q <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// difference vector: b - a for springs, a - b for repulsion
	always_comb begin
		pa[0] = {ax[COORD_W-1], ax};
		pa[1] = {ay[COORD_W-1], ay};
		pa[2] = {az[COORD_W-1], az};
		pb[0] = {bx[COORD_W-1], bx};
		pb[1] = {by[COORD_W-1], by};
		pb[2] = {bz[COORD_W-1], bz};
		front_in.spring = ~mode;
		front_in.pl = pref_length;
		front_in.za = size_a == '0;
		front_in.zb = size_b == '0;
		for (int i = 0; i < 3; i++) begin
			dd[i] = mode ? (pa[i] - pb[i]) : (pb[i] - pa[i]);
			front_in.sgn[i] = dd[i][COORD_W];
			front_in.u[i] = dd[i][COORD_W] ? MAG_W'(-dd[i]) : MAG_W'(dd[i]);
		end
		front_in.coin = (front_in.u[0] == '0) && (front_in.u[1] == '0)
			&& (front_in.u[2] == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
			v_s8 <= 1'b0;
			v_s9 <= 1'b0;
			v_s10 <= 1'b0;
			done <= 1'b0;
		end else begin
			v_s1 <= start & ~busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= vq;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
			v_s8 <= vm2;
			v_s9 <= v_s8;
			v_s10 <= v_s9;
			done <= v_s10;
		end
	end

	always_ff @(posedge clk) begin
		front_s1 <= front_in;
		sa_s1 <= size_a;
		sb_s1 <= size_b;
		front_s2 <= front_s1;
		sa_s2 <= sa_s1;
		sb_s2 <= sb_s1;
		for (int i = 0; i < 3; i++) begin
			sq_s2[i] <= front_s1.u[i] * front_s1.u[i];
		end
		front_s3 <= front_s2;
		sa_s3 <= sa_s2;
		sb_s3 <= sb_s2;
		sum_s3 <= sq_s2[0] + sq_s2[1] + sq_s2[2];
	end

	lpfk_isqrt u_sqrt_dist (
		.clk(clk), .arst_n(arst_n), .in_v(v_s3), .x(sum_s3), .out_v(vq), .root(root_d)
	);
	lpfk_isqrt u_sqrt_a (
		.clk(clk), .arst_n(arst_n), .in_v(v_s3),
		.x(SQ_IN_W'({sa_s3, {(2*FRAC_W){1'b0}}})), .out_v(), .root(root_a)
	);
	lpfk_isqrt u_sqrt_b (
		.clk(clk), .arst_n(arst_n), .in_v(v_s3),
		.x(SQ_IN_W'({sb_s3, {(2*FRAC_W){1'b0}}})), .out_v(), .root(root_b)
	);

	always_ff @(posedge clk) begin
		fdl_q[0] <= front_s3;
		for (int k = 1; k < SQ_LAT; k++) begin
			fdl_q[k] <= fdl_q[k-1];
		end
	end

	// radius sum, then per-mode numerators and denominators
	assign rad_prod = radius_unit_q * ssum_s4;

	always_comb begin
		dist_w = RADSUM_W'(dist_s5);
		pref_c = (RADSUM_W'(front_s5.pl) > radsum_s5) ? RADSUM_W'(front_s5.pl) : radsum_s5;
		num_c = (dist_w >= radsum_s5) ? (dist_w - radsum_s5) : (radsum_s5 - dist_w);
		k_c = K_W'(edge_length_q) + K_W'(radsum_s5);
		back_c.spring = front_s5.spring;
		back_c.neg = front_s5.spring && (dist_w < radsum_s5);
		back_c.ge = K_W'(dist_s5) >= k_c;
		back_c.coin = front_s5.coin;
		back_c.sgn = front_s5.sgn;
		back_c.u = front_s5.u;
	end

	always_ff @(posedge clk) begin
		front_s4 <= fdl_q[SQ_LAT-1];
		dist_s4 <= root_d;
		ssum_s4 <= SSUM_W'(fdl_q[SQ_LAT-1].za ? ROOT_ZERO : root_a[SROOT_W-1:0])
			+ SSUM_W'(fdl_q[SQ_LAT-1].zb ? ROOT_ZERO : root_b[SROOT_W-1:0]);
		front_s5 <= front_s4;
		dist_s5 <= dist_s4;
		radsum_s5 <= rad_prod[RAD_PROD_W-1:FRAC_W+1];
		back_s6 <= back_c;
		dist_s6 <= dist_s5;
		pref_s6 <= pref_c;
		num_s6 <= num_c;
		k_s6 <= k_c;
		back_s7 <= back_s6;
		if (back_s6.spring) begin
			na_s7 <= num_s6 * spring_weight_q;
			da_s7 <= {pref_s6, {FRAC_W{1'b0}}};
			nb_s7 <= force_cap_q * spring_weight_q;
			db_s7 <= DIV_D_W'({dist_s6, {FRAC_W{1'b0}}});
		end else begin
			na_s7 <= DIV_N_W'(k_s6);
			da_s7 <= DIV_D_W'(dist_s6);
			nb_s7 <= DIV_N_W'(force_cap_q);
			db_s7 <= DIV_D_W'(dist_s6);
		end
	end

	// divider a: law factor (or ratio k/dist); divider b: cap factor
	lpfk_div u_div_a (
		.clk(clk), .arst_n(arst_n), .in_v(v_s7), .num(na_s7), .den(da_s7),
		.out_v(vd), .quo(fa)
	);
	lpfk_div u_div_b (
		.clk(clk), .arst_n(arst_n), .in_v(v_s7), .num(nb_s7), .den(db_s7),
		.out_v(), .quo(fb)
	);

	lpfk_mul u_mul_sq (
		.clk(clk), .arst_n(arst_n), .in_v(vd), .a(fa), .b(fa), .out_v(vm1), .p(rr)
	);
	lpfk_mul u_mul_cube (
		.clk(clk), .arst_n(arst_n), .in_v(vm1), .a(rr), .b(m1_q[MUL_LAT-1].fa),
		.out_v(vm2), .p(rrr)
	);

	always_ff @(posedge clk) begin
		bdl_q[0] <= back_s7;
		for (int k = 1; k < DIV_LAT; k++) begin
			bdl_q[k] <= bdl_q[k-1];
		end
		m1_q[0] <= '{b: bdl_q[DIV_LAT-1], fa: fa, fb: fb};
		m2_q[0] <= '{m: m1_q[MUL_LAT-1], rr: rr};
		for (int k = 1; k < MUL_LAT; k++) begin
			m1_q[k] <= m1_q[k-1];
			m2_q[k] <= m2_q[k-1];
		end
	end

	// final factor: negative springs skip the cap
	always_comb begin
		if (m2_q[MUL_LAT-1].m.b.spring) begin
			g_c = m2_q[MUL_LAT-1].m.fa;
		end else begin
			g_c = m2_q[MUL_LAT-1].m.b.ge ? rrr : m2_q[MUL_LAT-1].rr;
		end
		if (m2_q[MUL_LAT-1].m.b.neg || g_c <= m2_q[MUL_LAT-1].m.fb) begin
			f_c = g_c;
		end else begin
			f_c = m2_q[MUL_LAT-1].m.fb;
		end
	end

	always_comb begin
		for (int i = 0; i < 3; i++) begin
			prod_c[i] = {ph_s9[i], {HALF_W{1'b0}}} + SCALE_W'(pl_s9[i]);
			mag_c[i] = prod_c[i][SCALE_W-1:FACT_FRAC];
		end
	end

	always_ff @(posedge clk) begin
		back_s8 <= m2_q[MUL_LAT-1].m.b;
		f_s8 <= f_c;
		back_s9 <= back_s8;
		back_s10 <= back_s9;
		for (int i = 0; i < 3; i++) begin
			ph_s9[i] <= back_s8.u[i] * f_s8[FACT_W-1:HALF_W];
			pl_s9[i] <= back_s8.u[i] * f_s8[HALF_W-1:0];
			// anything at or past 2^32 clips either way
			magc_s10[i] <= (|mag_c[i][SCALE_W-FACT_FRAC-1:FORCE_W]) ? MAGC_BIG
				: {1'b0, mag_c[i][FORCE_W-1:0]};
		end
	end

	always_comb begin
		cneg = 1'b0;
		mm = '0;
		for (int i = 0; i < 3; i++) begin
			cneg = back_s10.sgn[i] ^ back_s10.neg;
			if (!cneg) begin
				sat_c[i] = magc_s10[i] > POS_LIM;
				val_c[i] = sat_c[i] ? POS_LIM[FORCE_W-1:0] : magc_s10[i][FORCE_W-1:0];
			end else begin
				sat_c[i] = magc_s10[i] > NEG_LIM;
				mm = sat_c[i] ? NEG_LIM : magc_s10[i];
				val_c[i] = FORCE_W'(-mm[FORCE_W-1:0]);
			end
			if (back_s10.coin || (i == 2 && !layout_3d_q)) begin
				sat_c[i] = 1'b0;
				val_c[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		force_x <= val_c[0];
		force_y <= val_c[1];
		force_z <= val_c[2];
		saturated <= sat_c[0] | sat_c[1] | sat_c[2];
		coincident <= back_s10.coin;
	end
endmodule

// ===== test/layout_pair_force_kernel_checker.sv =====
// Checker for the pair force kernel: tracks registers, predicts each force word, compares.
`timescale 1ns / 1ps
module layout_pair_force_kernel_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	input  logic busy,
	input  logic cfg_we,
	input  logic [lpfk_pkg::REG_IDX_W-1:0] cfg_idx,
	input  logic [lpfk_pkg::CFG_DATA_W-1:0] cfg_wdata,
	input  logic mode,
	input  logic signed [lpfk_pkg::COORD_W-1:0] ax,
	input  logic signed [lpfk_pkg::COORD_W-1:0] ay,
	input  logic signed [lpfk_pkg::COORD_W-1:0] az,
	input  logic signed [lpfk_pkg::COORD_W-1:0] bx,
	input  logic signed [lpfk_pkg::COORD_W-1:0] by,
	input  logic signed [lpfk_pkg::COORD_W-1:0] bz,
	input  logic [lpfk_pkg::SIZE_W-1:0] size_a,
	input  logic [lpfk_pkg::SIZE_W-1:0] size_b,
	input  logic [lpfk_pkg::LEN_W-1:0] pref_length,
	input  logic done,
	input  logic signed [lpfk_pkg::FORCE_W-1:0] force_x,
	input  logic signed [lpfk_pkg::FORCE_W-1:0] force_y,
	input  logic signed [lpfk_pkg::FORCE_W-1:0] force_z,
	input  logic saturated,
	input  logic coincident,
	output int fail_count,
	output int pending,
	output int checked
);
	import lpfk_pkg::*;

	typedef struct packed {
		logic [FORCE_W-1:0] fx;
		logic [FORCE_W-1:0] fy;
		logic [FORCE_W-1:0] fz;
		logic sat;
		logic coin;
	} force_word_t;

	localparam bit [63:0] FMAX = 64'd1 << 55;
	localparam bit [63:0] MAG_CEIL = 64'd1 << 40;

	logic [LEN_W-1:0] edge_len_q, rad_unit_q;
	logic [WEIGHT_W-1:0] weight_q;
	logic [CAP_W-1:0] cap_q;
	logic is_3d_q;
	force_word_t expected_forces[$];

	function automatic bit [63:0] int_sqrt(input bit [63:0] x);
		bit [63:0] r, b;
		r = 0;
		b = 64'd1 << 62;
		while (b > x) b >>= 2;
		while (b != 0) begin
			if (x >= r + b) begin
				x = x - (r + b);
				r = (r >> 1) + b;
			end else r >>= 1;
			b >>= 2;
		end
		return r;
	endfunction

	// floor(num * 2^24 / den), saturating
	function automatic bit [63:0] fact_div(input bit [63:0] num, input bit [63:0] den);
		bit [63:0] q, r;
		if (den == 0) return (num != 0) ? FMAX : 64'd0;
		q = num / den;
		r = num % den;
		if (q >= (64'd1 << 31)) return FMAX;
		q <<= FACT_FRAC;
		for (int i = FACT_FRAC - 1; i >= 0; i--) begin
			if (r >= den - r) begin
				r = r - (den - r);
				q[i] = 1'b1;
			end else r <<= 1;
		end
		return q;
	endfunction

	function automatic bit [63:0] fact_mul(input bit [63:0] a, input bit [63:0] b);
		bit [63:0] ah, al, bh, bl, s;
		ah = a >> FACT_FRAC;
		al = a & ((64'd1 << FACT_FRAC) - 1);
		bh = b >> FACT_FRAC;
		bl = b & ((64'd1 << FACT_FRAC) - 1);
		if (ah != 0 && b > FMAX / ah) return FMAX;
		s = ah * b + al * bh + ((al * bl) >> FACT_FRAC);
		return (s > FMAX) ? FMAX : s;
	endfunction

	function automatic bit [63:0] size_sqrt(input bit [15:0] sz);
		if (sz == 0) return (64'd2 << FRAC_W) / 3;
		return int_sqrt(64'(sz) << (2 * FRAC_W));
	endfunction

	function automatic force_word_t predict_force();
		force_word_t w;
		longint signed dd[3];
		bit [63:0] ud[3], sq, sep, radsum, f, cf, maxabs, num, pref, k, r, mag;
		bit attract_neg, cneg, csat, spring;
		logic [FORCE_W-1:0] v;
		int sh;
		spring = !mode;
		dd[0] = spring ? longint'(bx) - longint'(ax) : longint'(ax) - longint'(bx);
		dd[1] = spring ? longint'(by) - longint'(ay) : longint'(ay) - longint'(by);
		dd[2] = spring ? longint'(bz) - longint'(az) : longint'(az) - longint'(bz);
		maxabs = 0;
		w = '0;
		attract_neg = 0;
		for (int i = 0; i < 3; i++) begin
			ud[i] = (dd[i] < 0) ? 64'(-dd[i]) : 64'(dd[i]);
			if (ud[i] > maxabs) maxabs = ud[i];
		end
		if (maxabs == 0) begin
			w.coin = 1'b1;
			return w;
		end
		sh = (maxabs >> 31) != 0 ? 1 : 0;
		sq = 0;
		for (int i = 0; i < 3; i++) sq += (ud[i] >> sh) * (ud[i] >> sh);
		sep = int_sqrt(sq) << sh;
		radsum = (64'(rad_unit_q) * (size_sqrt(size_a) + size_sqrt(size_b))) >> (FRAC_W + 1);
		if (spring) begin
			pref = (64'(pref_length) > radsum) ? 64'(pref_length) : radsum;
			if (sep >= radsum) num = sep - radsum;
			else begin
				num = radsum - sep;
				attract_neg = 1;
			end
			f = fact_div(num * weight_q, pref << 8);
			if (!attract_neg) begin
				cf = fact_div(64'(cap_q) * weight_q, sep << 8);
				if (cf < f) f = cf;
			end
		end else begin
			k = 64'(edge_len_q) + radsum;
			r = fact_div(k, sep);
			f = fact_mul(r, r);
			if (sep >= k) f = fact_mul(f, r);
			cf = fact_div(64'(cap_q), sep);
			if (cf < f) f = cf;
		end
		for (int i = 0; i < 3; i++) begin
			cneg = (dd[i] < 0) != attract_neg;
			csat = 0;
			if (f != 0 && ud[i] > 64'hFFFF_FFFF_FFFF_FFFF / f) mag = MAG_CEIL;
			else begin
				mag = (ud[i] * f) >> FACT_FRAC;
				if (mag > MAG_CEIL) mag = MAG_CEIL;
			end
			if (!cneg) begin
				if (mag > 64'h7FFF_FFFF) begin
					csat = 1;
					mag = 64'h7FFF_FFFF;
				end
				v = mag[31:0];
			end else begin
				if (mag > 64'h8000_0000) begin
					csat = 1;
					mag = 64'h8000_0000;
				end
				v = 32'(0 - mag);
			end
			if (i == 2 && !is_3d_q) begin
				v = 0;
				csat = 0;
			end
			if (csat) w.sat = 1'b1;
			case (i)
				0: w.fx = v;
				1: w.fy = v;
				default: w.fz = v;
			endcase
		end
		return w;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		force_word_t e;
		if (!arst_n) begin
			edge_len_q <= 24'd2560;
			rad_unit_q <= 24'd2560;
			weight_q <= 16'd256;
			cap_q <= 32'hFFFF_FFFF;
			is_3d_q <= 1'b0;
			fail_count <= 0;
			checked <= 0;
			expected_forces.delete();
		end else begin
			if (cfg_we) begin
				case (cfg_idx)
					REG_EDGE_LENGTH: edge_len_q <= cfg_wdata[LEN_W-1:0];
					REG_RADIUS_UNIT: rad_unit_q <= cfg_wdata[LEN_W-1:0];
					REG_SPRING_WGT: weight_q <= cfg_wdata[WEIGHT_W-1:0];
					REG_FORCE_CAP: cap_q <= cfg_wdata;
					REG_LAYOUT_3D: is_3d_q <= cfg_wdata[0];
					default: ;
				endcase
			end
			if (done) begin
				checked <= checked + 1;
				if (expected_forces.size() == 0) begin
					$error("force word with none expected");
					fail_count <= fail_count + 1;
				end else begin
					e = expected_forces.pop_front();
					if (e.fx !== force_x || e.fy !== force_y || e.fz !== force_z ||
						e.sat !== saturated || e.coin !== coincident)
						fail_count <= fail_count + 1;
					if (e.fx !== force_x)
						$error("force_x expected %0d got %0d", $signed(e.fx), force_x);
					if (e.fy !== force_y)
						$error("force_y expected %0d got %0d", $signed(e.fy), force_y);
					if (e.fz !== force_z)
						$error("force_z expected %0d got %0d", $signed(e.fz), force_z);
					if (e.sat !== saturated)
						$error("saturated expected %0d got %0d", e.sat, saturated);
					if (e.coin !== coincident)
						$error("coincident expected %0d got %0d", e.coin, coincident);
				end
			end
			if (start && !busy) expected_forces = {expected_forces, predict_force()};
		end
	end

	assign pending = expected_forces.size();
endmodule

// ===== test/layout_pair_force_kernel_top_test.sv =====
// Testbench top for the pair force kernel: stimulus, register phases and verdict.
`timescale 1ns / 1ps
module layout_pair_force_kernel_top_test;
	import lpfk_pkg::*;

	localparam int LATENCY = 100;
	localparam int CYCLE_LIMIT = 400000;
	localparam int ITEMS_PER_PHASE = 80;

	logic clk = 0;
	logic arst_n = 0;
	logic start = 0;
	logic busy;
	logic cfg_we = 0;
	logic [REG_IDX_W-1:0] cfg_idx = '0;
	logic [CFG_DATA_W-1:0] cfg_wdata = '0;
	logic mode = 0;
	logic signed [COORD_W-1:0] ax = 0, ay = 0, az = 0, bx = 0, by = 0, bz = 0;
	logic [SIZE_W-1:0] size_a = 0, size_b = 0;
	logic [LEN_W-1:0] pref_length = 0;
	logic done, saturated, coincident;
	logic signed [FORCE_W-1:0] force_x, force_y, force_z;
	int fail_count, pending, checked;
	int cycles = 0;
	int sent = 0;
	int idle_pct = 0;

	layout_pair_force_kernel_top u_top (.*);

	layout_pair_force_kernel_checker u_checker (.*);

	always begin
		#5 clk = 1;
		#5 clk = 0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("Regression FAIL");
			$finish;
		end
	end

	task automatic send_word(input logic m, input logic [23:0] pax, pay, paz, pbx, pby, pbz,
		input logic [15:0] sa, sb, input logic [23:0] pl);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			start <= 0;
		end
		@(negedge clk);
		start <= 1;
		mode <= m;
		ax <= pax; ay <= pay; az <= paz;
		bx <= pbx; by <= pby; bz <= pbz;
		size_a <= sa; size_b <= sb; pref_length <= pl;
		do @(posedge clk); while (busy);
		sent++;
	endtask

	task automatic drain();
		@(negedge clk);
		start <= 0;
		while (pending != 0) @(posedge clk);
		repeat (LATENCY + 10) @(posedge clk);
	endtask

	task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [31:0] val);
		@(negedge clk);
		cfg_we <= 1;
		cfg_idx <= idx;
		cfg_wdata <= val;
		@(negedge clk);
		cfg_we <= 0;
	endtask

	task automatic set_regs(input logic [31:0] el, ru, sw, cap, d3);
		write_reg(REG_EDGE_LENGTH, el);
		write_reg(REG_RADIUS_UNIT, ru);
		write_reg(REG_SPRING_WGT, sw);
		write_reg(REG_FORCE_CAP, cap);
		write_reg(REG_LAYOUT_3D, d3);
	endtask

	function automatic logic [23:0] near(input logic [23:0] base, input int span);
		return base + 24'($urandom_range(2 * span) - span);
	endfunction

	task automatic random_words(input int n);
		logic [23:0] b0, b1, b2;
		logic [15:0] sa, sb;
		int span;
		for (int i = 0; i < n; i++) begin
			b0 = 24'($urandom); b1 = 24'($urandom); b2 = 24'($urandom);
			sa = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
			sb = ($urandom_range(3) == 0) ? 16'($urandom) : 16'($urandom_range(8));
			span = ($urandom_range(1) == 0) ? 8000 : 64;
			case ($urandom_range(9))
				0, 1: send_word(1'($urandom), 24'($urandom), 24'($urandom), 24'($urandom),
					24'($urandom), 24'($urandom), 24'($urandom), sa, sb, 24'($urandom));
				2: send_word(1'($urandom), b0, b1, b2, b0, b1, b2, sa, sb, 24'($urandom));
				default: send_word(1'($urandom), b0, b1, b2, near(b0, span), near(b1, span),
					near(b2, span), sa, sb, 24'($urandom_range(6000)));
			endcase
		end
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;

		// directed: reset settings
		idle_pct = 32;
		send_word(0, 0, 0, 0, 24'd2560, 0, 0, 1, 1, 24'd2560);
		send_word(1, 0, 0, 0, 24'd2560, 0, 0, 1, 1, 0);
		send_word(0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
			16'hFFFF, 16'hFFFF, 24'hFFFFFF);
		send_word(1, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
			16'hFFFF, 16'hFFFF, 0);
		send_word(0, 24'h123456, 5, 24'h800000, 24'h123456, 5, 24'h800000, 3, 3, 100);
		send_word(1, 24'h123456, 5, 24'h800000, 24'h123456, 5, 24'h800000, 0, 0, 100);
		send_word(0, 0, 0, 0, 1, 0, 0, 0, 0, 0);
		send_word(1, 0, 0, 0, 1, 1, 1, 0, 0, 0);
		send_word(0, 0, 0, 0, 10, 0, 0, 9, 4, 24'hFFFFFF);
		send_word(0, 0, 0, 0, 0, 0, 24'd100000, 1, 1, 0);
		send_word(1, 100, 200, 300, 0, 0, 0, 2, 5, 0);
		random_words(ITEMS_PER_PHASE);
		drain();

		// 3D, zero cap, zero lengths
		set_regs(0, 0, 32'hFFFF, 0, 1);
		send_word(0, 0, 0, 0, 24'd1000, 24'd2000, 24'd3000, 1, 1, 0);
		send_word(1, 0, 0, 0, 24'd1000, 24'd2000, 24'd3000, 1, 1, 0);
		send_word(0, 24'd5000, 0, 0, 0, 0, 0, 0, 0, 0);
		random_words(ITEMS_PER_PHASE);
		drain();

		// extremes with 3D on
		set_regs(32'hFFFFFF, 32'hFFFFFF, 32'hFFFF, 32'hFFFFFFFF, 32'hFFFFFFFF);
		send_word(0, 24'h7FFFFF, 24'h7FFFFF, 24'h7FFFFF, 24'h800000, 24'h800000, 24'h800000,
			16'hFFFF, 16'hFFFF, 0);
		send_word(1, 0, 0, 0, 1, 0, 0, 16'hFFFF, 16'hFFFF, 0);
		random_words(ITEMS_PER_PHASE);
		drain();

		idle_pct = 82;
		set_regs(32'd2560, 32'd256, 32'd1, 32'd1000, 0);
		random_words(ITEMS_PER_PHASE);
		drain();

		set_regs($urandom, $urandom, $urandom, $urandom, 1);
		random_words(ITEMS_PER_PHASE);
		drain();

		idle_pct = 0;
		set_regs(32'd512, 32'd1280, 32'd256, 32'd400000, 1);
		random_words(ITEMS_PER_PHASE);
		drain();

		set_regs(32'd2560, 32'd2560, 32'd256, 32'hFFFFFFFF, 0);
		random_words(ITEMS_PER_PHASE);
		drain();

		$display("covered %0d force words over 7 register settings, both modes, 2D and 3D",
			sent);
		$display("%0d results checked, %0d mismatching", checked, fail_count);
		if (fail_count == 0 && pending == 0 && checked == sent)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule
